FILE: rtl/core/srf_pkg.sv
// Shared types, constants and slot helper for the scheduled rotation feeder sequencer.
package srf_pkg;

  localparam int SLOT_W    = 19;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int ROT_W     = 8;
  localparam int WAIT_W    = 11;
  localparam int SPEED_W   = 6;
  localparam int FEEDS_W   = 8;
  localparam int TOTAL_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_SLOT_REGS = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd5;

  localparam logic [SLOT_W-1:0]  SLOT_RESET  = 19'd2047;
  localparam logic [WAIT_W-1:0]  WAIT_RESET  = 11'd1500;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 6'h3e;
  localparam logic [HOUR_W-1:0]  HOUR_MAX    = 5'd23;
  localparam logic [MIN_W-1:0]   MIN_MAX     = 6'd59;
  localparam logic [FEEDS_W-1:0] FEEDS_SAT   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT   = '1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAVE,
    PH_RETURN
  } phase_t;

  typedef struct packed {
    logic              func;
    logic [HOUR_W-1:0] hour_now;
    logic [MIN_W-1:0]  minute_now;
    logic              switch_level;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] motor_drive;
    logic               feed_done;
    logic [ROT_W-1:0]   rotations_done;
    logic [FEEDS_W-1:0] feeds_count;
    logic [TOTAL_W-1:0] rotations_count;
  } out_t;

  typedef struct packed {
    phase_t             phase;
    logic [WAIT_W-1:0]  wait_ticks;
    logic [ROT_W-1:0]   rotations_target;
    logic [ROT_W-1:0]   rotations_started;
    logic [FEEDS_W-1:0] feeds_total;
    logic [TOTAL_W-1:0] rotations_total;
  } seq_state_t;

  typedef struct packed {
    logic               schedule_enable;
    logic [WAIT_W-1:0]  wait_limit;
    logic [SPEED_W-1:0] motor_speed;
  } seq_cfg_t;

  // A slot is due when its time is set, its rotation count is nonzero and the
  // wall clock has reached its time.
  function automatic logic slot_ready(input logic [SLOT_W-1:0] word,
                                      input logic [HOUR_W-1:0] hh,
                                      input logic [MIN_W-1:0]  mm);
    logic [HOUR_W-1:0] h;
    logic [MIN_W-1:0]  m;
    logic [ROT_W-1:0]  r;
    h = word[HOUR_W-1:0];
    m = word[HOUR_W+MIN_W-1:HOUR_W];
    r = word[SLOT_W-1:HOUR_W+MIN_W];
    if (h > HOUR_MAX || m > MIN_MAX || r == '0) begin
      return 1'b0;
    end
    return (hh > h) || ((hh >= h) && (mm >= m));
  endfunction

endpackage

FILE: rtl/core/srf_step.sv
// Per-tick next-state and result logic of the feeder sequencer.
module srf_step import srf_pkg::*; #(
  parameter int SLOT_COUNT = 3
) (
  input  seq_cfg_t          cfg,
  input  logic [SLOT_W-1:0] slots [NUM_SLOT_REGS],
  input  seq_state_t        cur,
  input  in_t               item,
  output seq_state_t        nxt,
  output out_t              res
);

  localparam int NREG = (SLOT_COUNT < NUM_SLOT_REGS) ? SLOT_COUNT : NUM_SLOT_REGS;

  logic [SLOT_W-1:0] words [SLOT_COUNT];

  genvar g;
  generate
    for (g = 0; g < NREG; g++) begin : g_reg_slot
      assign words[g] = slots[g];
    end
    for (g = NREG; g < SLOT_COUNT; g++) begin : g_unset_slot
      assign words[g] = SLOT_RESET;
    end
  endgenerate

  logic             start_hit;
  logic [ROT_W-1:0] start_rot;
  logic             tick;
  logic             active;
  logic             waiting;
  logic             timeout;
  logic             to_return;
  logic             finish_ok;
  logic             next_rot;
  logic             done;
  logic [ROT_W-1:0] success;
  logic             start;
  logic [TOTAL_W:0] rot_sum;
  phase_t           phase_nxt;

  // Scan from slot feeds_total upward; the lowest due slot wins.
  always_comb begin
    start_hit = 1'b0;
    start_rot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if ((FEEDS_W'(i) >= cur.feeds_total) &&
          slot_ready(words[i], item.hour_now, item.minute_now)) begin
        start_hit = 1'b1;
        start_rot = words[i][SLOT_W-1:HOUR_W+MIN_W];
      end
    end
  end

  always_comb begin
    tick      = !item.func;
    active    = tick && (cur.phase == PH_LEAVE || cur.phase == PH_RETURN);
    start     = tick && (cur.phase == PH_IDLE) && cfg.schedule_enable && start_hit;
    waiting   = active && (item.switch_level == (cur.phase == PH_RETURN));
    timeout   = waiting && (cur.wait_ticks >= cfg.wait_limit);
    to_return = active && !waiting && (cur.phase == PH_LEAVE);
    finish_ok = active && !waiting && (cur.phase == PH_RETURN) &&
                (cur.rotations_started >= cur.rotations_target);
    next_rot  = active && !waiting && (cur.phase == PH_RETURN) && !finish_ok;
    done      = timeout || finish_ok;
    success   = finish_ok ? cur.rotations_started : '0;
  end

  // Next phase.
  always_comb begin
    phase_nxt = cur.phase;
    unique case (cur.phase)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_LEAVE;
        end
      end
      PH_LEAVE: begin
        if (timeout) begin
          phase_nxt = PH_IDLE;
        end else if (to_return) begin
          phase_nxt = PH_RETURN;
        end
      end
      PH_RETURN: begin
        if (done) begin
          phase_nxt = PH_IDLE;
        end else if (next_rot) begin
          phase_nxt = PH_LEAVE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Counters and the result item.
  always_comb begin
    nxt.phase             = phase_nxt;
    nxt.wait_ticks        = cur.wait_ticks;
    nxt.rotations_target  = cur.rotations_target;
    nxt.rotations_started = cur.rotations_started;
    nxt.feeds_total       = cur.feeds_total;
    nxt.rotations_total   = cur.rotations_total;
    rot_sum = {1'b0, cur.rotations_total} + {{(TOTAL_W+1-ROT_W){1'b0}}, success};

    if (item.func) begin
      nxt.feeds_total     = '0;
      nxt.rotations_total = '0;
    end else if (start) begin
      nxt.rotations_target  = start_rot;
      nxt.rotations_started = ROT_W'(1);
      nxt.wait_ticks        = '0;
    end else if (done) begin
      nxt.wait_ticks = '0;
      if (cur.feeds_total != FEEDS_SAT) begin
        nxt.feeds_total = cur.feeds_total + FEEDS_W'(1);
      end
      nxt.rotations_total = rot_sum[TOTAL_W] ? TOTAL_SAT : rot_sum[TOTAL_W-1:0];
    end else if (waiting) begin
      nxt.wait_ticks = cur.wait_ticks + WAIT_W'(1);
    end else if (to_return) begin
      nxt.wait_ticks = '0;
    end else if (next_rot) begin
      nxt.rotations_started = cur.rotations_started + ROT_W'(1);
      nxt.wait_ticks        = '0;
    end

    res.motor_drive     = (phase_nxt != PH_IDLE) ? cfg.motor_speed : '0;
    res.feed_done       = done;
    res.rotations_done  = success;
    res.feeds_count     = nxt.feeds_total;
    res.rotations_count = nxt.rotations_total;
  end

endmodule

FILE: rtl/core/scheduled_rotation_feeder_sequencer.sv
// Top level of the scheduled rotation feeder sequencer: ports, registers and pipeline control.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    in_data   (in_t: func, hour, minute, switch)
//   out_      output     out_valid / out_ready  out_data  (out_t: drive, done, counts)
//   cfg_      input      cfg_valid / cfg_ready  cfg_index (3 bits), cfg_data (19 bits)
//
// A transaction on in_ is captured in an input register, evaluated against the sequencer
// state once the output register is free or being drained, and its result is loaded
// into the output register; one transaction is taken every cycle while out_ready is high.
// This rate is set by the sequencer state, which is updated as each transaction is
// evaluated. When out_ready is low the output register holds its transaction and the
// input register still takes one more, so in_ready drops only once both are full.
// rst_n is synchronous and active low; it clears the state and both valid flags and
// loads the configuration registers with their reset values. cfg_ready is always high.
module scheduled_rotation_feeder_sequencer import srf_pkg::*; #(
  parameter int SLOT_COUNT = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLOT_W-1:0]    cfg_data
);

  // Configuration registers.
  seq_cfg_t          cfg_r;
  logic [SLOT_W-1:0] slot_r [NUM_SLOT_REGS];

  // Sequencer state.
  seq_state_t state_r;
  seq_state_t state_nxt;

  // Input register and output register.
  logic in_valid_r;
  in_t  in_data_r;
  logic out_valid_r;
  out_t out_data_r;
  out_t result;

  logic advance;
  logic cfg_we;

  // The stored transaction moves on when the output register is free or drains now.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  srf_step #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_step (
    .cfg  (cfg_r),
    .slots(slot_r),
    .cur  (state_r),
    .item (in_data_r),
    .nxt  (state_nxt),
    .res  (result)
  );

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.schedule_enable <= 1'b0;
      cfg_r.wait_limit      <= WAIT_RESET;
      cfg_r.motor_speed     <= SPEED_RESET;
      for (int i = 0; i < NUM_SLOT_REGS; i++) begin
        slot_r[i] <= SLOT_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: cfg_r.schedule_enable <= cfg_data[0];
        REG_SLOT0:  slot_r[0]             <= cfg_data;
        REG_SLOT1:  slot_r[1]             <= cfg_data;
        REG_SLOT2:  slot_r[2]             <= cfg_data;
        REG_WAIT:   cfg_r.wait_limit      <= cfg_data[WAIT_W-1:0];
        REG_SPEED:  cfg_r.motor_speed     <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // The state advances exactly once per transaction, when it is evaluated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase             <= PH_IDLE;
      state_r.wait_ticks        <= '0;
      state_r.rotations_target  <= '0;
      state_r.rotations_started <= '0;
      state_r.feeds_total       <= '0;
      state_r.rotations_total   <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

endmodule

FILE: rtl/core/srf_checker.sv
// Port-level checker for the feeder sequencer and its bind to the top level.
module srf_checker import srf_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A held result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A finished feed has been counted.
  a_done_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.feed_done |-> out_data.feeds_count != '0)
    else $error("finished feed not counted");

  // Success is reported only with a finished feed.
  a_success_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.feed_done |-> out_data.rotations_done == '0)
    else $error("rotations reported without a finished feed");

  // The motor stops on the tick a feed finishes.
  a_motor_off_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.feed_done |-> out_data.motor_drive == '0)
    else $error("motor still driven after the feed finished");

  // The rotation total includes the rotations of the finished feed.
  a_total_covers_feed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.feed_done |->
      out_data.rotations_count >= {{(TOTAL_W-ROT_W){1'b0}}, out_data.rotations_done})
    else $error("rotation total below the finished feed's rotations");

endmodule

bind scheduled_rotation_feeder_sequencer srf_checker u_srf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
